FILE: design/sgb_pkg.sv
// shared types, register codes and arithmetic helpers for the separable gaussian blur
// no dependencies; used by scoped names in sgb_cfg, sgb_mac and the top level
`default_nettype none

package sgb_pkg;

    localparam int ACC_W  = 36;
    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;

    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_BAND_COUNT   = 3'd2;
    localparam logic [2:0] REG_RADIUS       = 3'd3;
    localparam logic [2:0] REG_COEF_NEAR    = 3'd4;
    localparam logic [2:0] REG_COEF_FAR     = 3'd5;

    localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd1024;
    localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd1024;
    localparam logic [2:0]  RST_BAND_COUNT   = 3'd1;
    localparam logic [2:0]  RST_RADIUS       = 3'd0;
    localparam logic [63:0] RST_COEF_NEAR    = 64'd32768;
    localparam logic [63:0] RST_COEF_FAR     = 64'd0;

    typedef struct packed {
        logic [10:0] image_width;
        logic [10:0] image_height;
        logic [2:0]  band_count;
        logic [2:0]  radius;
        logic [63:0] coefficients_near;
        logic [63:0] coefficients_far;
        logic        restart;
    } cfg_t;

    typedef struct packed {
        logic clear;
        logic en;
    } mac_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WIN,
        ST_HMAC,
        ST_HDRAIN,
        ST_HRND,
        ST_VSTART,
        ST_VMAC,
        ST_VDRAIN,
        ST_VEMIT,
        ST_PEMIT
    } seq_state_t;

    function automatic logic [15:0] tap_of(input logic [63:0] near_c,
                                           input logic [63:0] far_c,
                                           input logic [2:0]  distance);
        logic [63:0] sel;
        sel = distance[2] ? far_c : near_c;
        return sel[16 * distance[1:0] +: 16];
    endfunction

    function automatic logic [15:0] round_sat(input logic [ACC_W-1:0] acc);
        logic [ACC_W:0]    s;
        logic [ACC_W-15:0] q;
        s = {1'b0, acc} + (ACC_W + 1)'(16384);
        q = s[ACC_W:15];
        return (|q[ACC_W-15:16]) ? 16'hFFFF : q[15:0];
    endfunction

    function automatic logic [2:0] abs_diff(input logic [3:0] a, input logic [3:0] b);
        return (a > b) ? 3'(a - b) : 3'(b - a);
    endfunction

endpackage

`default_nettype wire

FILE: design/sgb_cfg.sv
// configuration registers behind the apb-style port
// depends on sgb_pkg for register codes, reset values and cfg_t
`default_nettype none

module sgb_cfg (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [sgb_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [sgb_pkg::DATA_W-1:0]  pwdata,
    output logic      [sgb_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    output sgb_pkg::cfg_t                    cfg
);

    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic [2:0]  bands_reg;
    logic [2:0]  radius_reg;
    logic [63:0] near_reg;
    logic [63:0] far_reg;
    logic [2:0]  idx;
    logic        wr;
    logic        known;

    assign idx    = paddr[5:3];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        known  = 1'b1;
        prdata = '0;
        case (idx)
            sgb_pkg::REG_IMAGE_WIDTH:  prdata = 64'(width_reg);
            sgb_pkg::REG_IMAGE_HEIGHT: prdata = 64'(height_reg);
            sgb_pkg::REG_BAND_COUNT:   prdata = 64'(bands_reg);
            sgb_pkg::REG_RADIUS:       prdata = 64'(radius_reg);
            sgb_pkg::REG_COEF_NEAR:    prdata = near_reg;
            sgb_pkg::REG_COEF_FAR:     prdata = far_reg;
            default:                   known  = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= sgb_pkg::RST_IMAGE_WIDTH;
            height_reg <= sgb_pkg::RST_IMAGE_HEIGHT;
            bands_reg  <= sgb_pkg::RST_BAND_COUNT;
            radius_reg <= sgb_pkg::RST_RADIUS;
            near_reg   <= sgb_pkg::RST_COEF_NEAR;
            far_reg    <= sgb_pkg::RST_COEF_FAR;
        end
        else if (wr)
        begin
            case (idx)
                sgb_pkg::REG_IMAGE_WIDTH:  width_reg  <= pwdata[10:0];
                sgb_pkg::REG_IMAGE_HEIGHT: height_reg <= pwdata[10:0];
                sgb_pkg::REG_BAND_COUNT:   bands_reg  <= pwdata[2:0];
                sgb_pkg::REG_RADIUS:       radius_reg <= pwdata[2:0];
                sgb_pkg::REG_COEF_NEAR:    near_reg   <= pwdata;
                sgb_pkg::REG_COEF_FAR:     far_reg    <= pwdata;
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        cfg.image_width       = width_reg;
        cfg.image_height      = height_reg;
        cfg.band_count        = bands_reg;
        cfg.radius            = radius_reg;
        cfg.coefficients_near = near_reg;
        cfg.coefficients_far  = far_reg;
        // a known register write restarts the frame
        cfg.restart           = wr && known;
    end

endmodule

`default_nettype wire

FILE: design/sgb_mac.sv
// shared multiply-accumulate unit: registered product, then accumulate
// depends on sgb_pkg for mac_ctl_t and the accumulator width
`default_nettype none

module sgb_mac (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire sgb_pkg::mac_ctl_t           ctl,
    input  wire logic [15:0]                 coef,
    input  wire logic [15:0]                 sample,
    output logic      [sgb_pkg::ACC_W-1:0]   acc
);

    logic [31:0]               prod_reg;
    logic                      pv_reg;
    logic [sgb_pkg::ACC_W-1:0] acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= 1'b0;
        else
            pv_reg <= ctl.en;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
            prod_reg <= coef * sample;
        if (ctl.clear)
            acc_reg <= '0;
        else if (pv_reg)
            acc_reg <= acc_reg + sgb_pkg::ACC_W'(prod_reg);
    end

    assign acc = acc_reg;

    // a new sum never starts while a product is still in flight
    a_clear_drained: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |-> !pv_reg)
        else $error("accumulator cleared with a product pending");

endmodule

`default_nettype wire

FILE: design/sgb_line_mem.sv
// line store of horizontal results, one write and one registered read port
// no package dependency
`default_nettype none

module sgb_line_mem #(
    parameter int DEPTH = 57344,
    parameter int AW    = 16
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [15:0]   wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [15:0]   rdata
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: design/separable_gaussian_blur.sv
// top level: sequencer, per-band row window memory, counters and output register
// depends on sgb_pkg, sgb_cfg, sgb_mac and sgb_line_mem
//
//  channel   signals                               direction
//  input     in_valid, in_ready, sample_value      samples in raster order, band fastest
//  output    out_valid, out_ready, result fields   0 to 4 results per sample
//  config    psel, penable, pwrite, paddr, pwdata  64-bit registers at 8*index
//
// one sample is handled at a time; a sample goes through acceptance and the row window update,
// the horizontal sum when that column is interior, and for each horizontal value a start step,
// a pass through the line store and the vertical result when the row is interior, and a step
// for the pass-through result and write-back, all bounded by the single multiplier and the
// single line store read port.
// a stalled output holds the sequencer at its emit step; reset clears counters and the
// row window valid bits, the line store needs no clearing pass.
`default_nettype none

module separable_gaussian_blur #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_BANDS  = 4,
    parameter int MAX_RADIUS = 7
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [15:0]                 sample_value,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic      [15:0]                 filtered_value,
    output logic      [9:0]                  out_row,
    output logic      [9:0]                  out_column,
    output logic      [1:0]                  out_band,
    output logic                             last_of_run,
    output logic                             frame_done,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [sgb_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [sgb_pkg::DATA_W-1:0]  pwdata,
    output logic      [sgb_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);

    localparam int TAPS   = 2 * MAX_RADIUS + 1;
    localparam int KW     = $clog2(TAPS);
    localparam int SW     = $clog2(2 * MAX_RADIUS);
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int BW     = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
    localparam int MAXD   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DW     = ($clog2(MAXD) + 2 > 12) ? $clog2(MAXD) + 2 : 12;
    localparam int LDEPTH = 2 * MAX_RADIUS * MAX_WIDTH * MAX_BANDS;
    localparam int LAW    = $clog2(LDEPTH);

    typedef logic [TAPS-1:0][15:0] win_t;

    sgb_pkg::cfg_t            cfg;
    sgb_pkg::mac_ctl_t        mac_ctl;
    sgb_pkg::seq_state_t      state_reg, state_next;
    logic [sgb_pkg::ACC_W-1:0] acc;
    logic [15:0]              mac_coef;
    logic [15:0]              mac_sample;

    // configuration, clamped
    logic [DW-1:0] eff_w, eff_h, w_raw, h_raw;
    logic [2:0]    eff_nb, eff_r;
    logic [3:0]    two_r;

    // position counters
    logic [CW-1:0] col_cnt;
    logic [RW-1:0] row_cnt;
    logic [BW-1:0] band_cnt;
    logic [SW-1:0] slot_cnt;
    logic [DW-1:0] cd, jd, rd, r2d;
    logic          col_wrap, row_wrap, band_wrap, accept;

    // item registers
    logic [15:0]   x_reg, hv_reg;
    logic [CW-1:0] c_reg, vcol_reg;
    logic [RW-1:0] j_reg;
    logic [BW-1:0] b_reg;
    logic [SW-1:0] base_slot_reg, rslot_reg;
    logic          hi_reg, hp_reg, vi_reg, vp_reg, lastpos_reg, stage_int_reg;
    logic [KW-1:0] k_reg, rk_reg;
    logic [2:0]    dist_reg;
    logic          rv_reg;
    logic          more_after;

    // row window memory, one row per band
    win_t          wmem [MAX_BANDS];
    logic [MAX_BANDS-1:0] wvalid_reg;
    win_t          wrd_reg, win_reg, shifted;
    logic          wvld_reg;

    // line store ports
    logic            lm_we, rd_issue;
    logic [SW-1:0]   rd_slot;
    logic [15:0]     lm_rdata;
    logic [LAW-1:0]  lm_waddr, lm_raddr;

    // output register
    logic            out_valid_reg, out_free, emit, emit_last, second_stage;
    logic [15:0]     emit_value, value_reg;
    logic [RW-1:0]   emit_row;
    logic [9:0]      row_out_reg, col_out_reg;
    logic [1:0]      band_out_reg;
    logic            last_reg, done_reg;

    function automatic logic [SW-1:0] slot_dec(input logic [SW-1:0] s, input logic [3:0] tr);
        return (s == '0) ? SW'(tr - 4'd1) : s - SW'(1);
    endfunction

    function automatic logic [LAW-1:0] lm_addr(input logic [SW-1:0] s,
                                               input logic [CW-1:0] col,
                                               input logic [BW-1:0] bd);
        return (LAW'(s) * LAW'(MAX_WIDTH) + LAW'(col)) * LAW'(MAX_BANDS) + LAW'(bd);
    endfunction

    sgb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sgb_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .coef   (mac_coef),
        .sample (mac_sample),
        .acc    (acc)
    );

    sgb_line_mem #(
        .DEPTH (LDEPTH),
        .AW    (LAW)
    ) u_line (
        .clk   (clk),
        .we    (lm_we),
        .waddr (lm_waddr),
        .wdata (hv_reg),
        .re    (rd_issue),
        .raddr (lm_raddr),
        .rdata (lm_rdata)
    );

    always_comb
    begin
        w_raw  = DW'(cfg.image_width);
        h_raw  = DW'(cfg.image_height);
        eff_w  = (w_raw == '0) ? DW'(1) : ((w_raw > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : w_raw);
        eff_h  = (h_raw == '0) ? DW'(1) :
                 ((h_raw > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : h_raw);
        eff_nb = (cfg.band_count == 3'd0) ? 3'd1 :
                 ((cfg.band_count > 3'(MAX_BANDS)) ? 3'(MAX_BANDS) : cfg.band_count);
        eff_r  = (cfg.radius > 3'(MAX_RADIUS)) ? 3'(MAX_RADIUS) : cfg.radius;
        two_r  = {eff_r, 1'b0};
        cd     = DW'(col_cnt);
        jd     = DW'(row_cnt);
        rd     = DW'(eff_r);
        r2d    = DW'(two_r);
        band_wrap = DW'(band_cnt) + DW'(1) >= DW'(eff_nb);
        col_wrap  = cd + DW'(1) >= eff_w;
        row_wrap  = jd + DW'(1) >= eff_h;
    end

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign more_after = stage_int_reg && hp_reg && (vi_reg || vp_reg);
    assign second_stage = stage_int_reg && hp_reg;
    assign shifted  = wvld_reg ? {wrd_reg[TAPS-2:0], x_reg} : {{(TAPS-1){16'h0}}, x_reg};
    assign lm_waddr = lm_addr(base_slot_reg, vcol_reg, b_reg);
    assign lm_raddr = lm_addr(rd_slot, vcol_reg, b_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= sgb_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        mac_ctl    = '0;
        mac_coef   = '0;
        mac_sample = '0;
        rd_issue   = 1'b0;
        rd_slot    = rslot_reg;
        lm_we      = 1'b0;
        emit       = 1'b0;
        emit_value = hv_reg;
        emit_row   = j_reg;
        emit_last  = 1'b0;
        case (state_reg)
            sgb_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    state_next = sgb_pkg::ST_WIN;
            end
            sgb_pkg::ST_WIN:
            begin
                mac_ctl.clear = 1'b1;
                if (hi_reg)
                    state_next = sgb_pkg::ST_HMAC;
                else if (hp_reg)
                    state_next = sgb_pkg::ST_VSTART;
                else
                    state_next = sgb_pkg::ST_IDLE;
            end
            sgb_pkg::ST_HMAC:
            begin
                mac_ctl.en = 1'b1;
                mac_coef   = sgb_pkg::tap_of(cfg.coefficients_near, cfg.coefficients_far,
                                             sgb_pkg::abs_diff(4'(k_reg), {1'b0, eff_r}));
                mac_sample = win_reg[0];
                if (4'(k_reg) == two_r)
                    state_next = sgb_pkg::ST_HDRAIN;
            end
            sgb_pkg::ST_HDRAIN:
                state_next = sgb_pkg::ST_HRND;
            sgb_pkg::ST_HRND:
                state_next = sgb_pkg::ST_VSTART;
            sgb_pkg::ST_VSTART:
            begin
                mac_ctl.clear = 1'b1;
                mac_ctl.en    = 1'b1;
                mac_coef      = sgb_pkg::tap_of(cfg.coefficients_near,
                                                cfg.coefficients_far, eff_r);
                mac_sample    = hv_reg;
                if (vi_reg)
                begin
                    if (eff_r != 3'd0)
                    begin
                        rd_issue   = 1'b1;
                        rd_slot    = slot_dec(base_slot_reg, two_r);
                        state_next = sgb_pkg::ST_VMAC;
                    end
                    else
                        state_next = sgb_pkg::ST_VDRAIN;
                end
                else
                    state_next = sgb_pkg::ST_PEMIT;
            end
            sgb_pkg::ST_VMAC:
            begin
                if (rv_reg)
                begin
                    mac_ctl.en = 1'b1;
                    mac_coef   = sgb_pkg::tap_of(cfg.coefficients_near,
                                                 cfg.coefficients_far, dist_reg);
                    mac_sample = lm_rdata;
                end
                if (4'(rk_reg) < two_r)
                begin
                    rd_issue = 1'b1;
                    rd_slot  = slot_dec(rslot_reg, two_r);
                end
                else
                    state_next = sgb_pkg::ST_VDRAIN;
            end
            sgb_pkg::ST_VDRAIN:
                state_next = sgb_pkg::ST_VEMIT;
            sgb_pkg::ST_VEMIT:
            begin
                emit_value = sgb_pkg::round_sat(acc);
                emit_row   = j_reg - RW'(eff_r);
                emit_last  = !vp_reg && !more_after;
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = sgb_pkg::ST_PEMIT;
                end
            end
            sgb_pkg::ST_PEMIT:
            begin
                emit_last = !more_after;
                if (!vp_reg || out_free)
                begin
                    emit  = vp_reg;
                    lm_we = (eff_r != 3'd0);
                    state_next = second_stage ? sgb_pkg::ST_VSTART : sgb_pkg::ST_IDLE;
                end
            end
            default:
                state_next = sgb_pkg::ST_IDLE;
        endcase
    end

    // counters follow accepted transfers; a write to a known register restarts the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt  <= '0;
            row_cnt  <= '0;
            band_cnt <= '0;
            slot_cnt <= '0;
        end
        else if (cfg.restart)
        begin
            col_cnt  <= '0;
            row_cnt  <= '0;
            band_cnt <= '0;
            slot_cnt <= '0;
        end
        else if (accept)
        begin
            band_cnt <= band_wrap ? '0 : band_cnt + BW'(1);
            if (band_wrap)
            begin
                col_cnt <= col_wrap ? '0 : col_cnt + CW'(1);
                if (col_wrap)
                begin
                    row_cnt <= row_wrap ? '0 : row_cnt + RW'(1);
                    if (row_wrap || eff_r == 3'd0)
                        slot_cnt <= '0;
                    else
                        slot_cnt <= (4'(slot_cnt) + 4'd1 == two_r) ? '0 : slot_cnt + SW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wvalid_reg <= '0;
            rv_reg     <= 1'b0;
        end
        else
        begin
            rv_reg <= rd_issue;
            if (state_reg == sgb_pkg::ST_WIN)
                wvalid_reg[b_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg         <= sample_value;
            c_reg         <= col_cnt;
            j_reg         <= row_cnt;
            b_reg         <= band_cnt;
            base_slot_reg <= slot_cnt;
            hi_reg        <= cd >= r2d;
            hp_reg        <= (cd < rd) || (cd + rd >= eff_w);
            vi_reg        <= jd >= r2d;
            vp_reg        <= (jd < rd) || (jd + rd >= eff_h);
            lastpos_reg   <= band_wrap && col_wrap && row_wrap;
            wrd_reg       <= wmem[band_cnt];
            wvld_reg      <= wvalid_reg[band_cnt];
        end
        case (state_reg)
            sgb_pkg::ST_WIN:
            begin
                wmem[b_reg] <= shifted;
                win_reg     <= shifted;
                k_reg       <= '0;
                hv_reg        <= x_reg;
                vcol_reg      <= c_reg;
                stage_int_reg <= 1'b0;
            end
            sgb_pkg::ST_HMAC:
            begin
                win_reg <= {16'h0, win_reg[TAPS-1:1]};
                k_reg   <= k_reg + KW'(1);
            end
            sgb_pkg::ST_HRND:
            begin
                hv_reg        <= sgb_pkg::round_sat(acc);
                vcol_reg      <= CW'(DW'(c_reg) - DW'(eff_r));
                stage_int_reg <= 1'b1;
            end
            sgb_pkg::ST_VSTART:
            begin
                rk_reg    <= KW'(1);
                rslot_reg <= slot_dec(base_slot_reg, two_r);
                dist_reg  <= sgb_pkg::abs_diff(4'd1, {1'b0, eff_r});
            end
            sgb_pkg::ST_VMAC:
            begin
                if (rd_issue)
                begin
                    rk_reg    <= rk_reg + KW'(1);
                    rslot_reg <= rd_slot;
                    dist_reg  <= sgb_pkg::abs_diff(4'(rk_reg) + 4'd1, {1'b0, eff_r});
                end
            end
            sgb_pkg::ST_PEMIT:
            begin
                if (state_next == sgb_pkg::ST_VSTART)
                begin
                    hv_reg        <= x_reg;
                    vcol_reg      <= c_reg;
                    stage_int_reg <= 1'b0;
                end
            end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            value_reg    <= emit_value;
            row_out_reg  <= 10'(emit_row);
            col_out_reg  <= 10'(vcol_reg);
            band_out_reg <= 2'(b_reg);
            last_reg     <= emit_last;
            done_reg     <= emit_last && lastpos_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign filtered_value = value_reg;
    assign out_row        = row_out_reg;
    assign out_column     = col_out_reg;
    assign out_band       = band_out_reg;
    assign last_of_run    = last_reg;
    assign frame_done     = done_reg;

    a_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> last_of_run)
        else $error("frame end flagged on a result that is not last of its run");

    // line store data is only ever consumed by the read loop
    a_read_consumed: assert property (@(posedge clk) disable iff (!rst_n)
        rv_reg |-> state_reg == sgb_pkg::ST_VMAC)
        else $error("line store read data arrived outside the read loop");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        eff_r != 3'd0 |-> 4'(slot_cnt) < two_r)
        else $error("line slot pointer outside the ring");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.restart |=> col_cnt == '0 && row_cnt == '0 && band_cnt == '0)
        else $error("counters not cleared by register write");

endmodule

`default_nettype wire
